@@ rtl/ccr_pkg.sv @@
`timescale 1ns / 1ps

package ccr_pkg;

  localparam int unsigned XW    = 32;   // cosine point, Q2.30
  localparam int unsigned CW    = 32;   // scale and gain, Q8.24
  localparam int unsigned VW    = 64;   // recurrence values, Q40.24
  localparam int unsigned MW    = 6;    // mode index
  localparam int unsigned NW    = 7;    // mode count register
  localparam int unsigned IDXW  = 2;    // config register index
  localparam int unsigned OUTW  = 200;  // result tdata, padded to bytes

  localparam logic [NW-1:0] ModeCountRst = 7'd64;
  localparam logic [CW-1:0] ScaleRst     = 32'h0100_0000;
  localparam logic [CW-1:0] GainRst      = 32'h0100_0000;

  localparam logic signed [VW-1:0] SatMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VW-1:0] SatMin = 64'sh8000_0000_0000_0000;

  typedef enum logic [IDXW-1:0] {
    CFG_MODE_COUNT = 2'd0,
    CFG_AMP_SCALE  = 2'd1,
    CFG_DERIV_GAIN = 2'd2
  } cfg_idx_e;

  // Right shift applied after a product
  typedef enum logic [1:0] {
    SH_24,
    SH_29,
    SH_30
  } sh_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,      // capture x, mode 0 base values
    OP_MUL_SX,
    OP_BASE1,     // mode 1 base values
    OP_MUL_PX,
    OP_T,
    OP_MUL_FX,
    OP_ACC_2P,
    OP_ACC_MR,
    OP_D1,
    OP_ACC_2F,
    OP_ACC_DBL,
    OP_MUL_SECX,
    OP_D2,
    OP_SHIFT,     // push t, d1, d2 into history
    OP_MUL_D1G,
    OP_O1,
    OP_MUL_D2G,
    OP_MUL_MRG,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SX_START,
    ST_SX_WAIT,
    ST_BASE1,
    ST_PX_START,
    ST_PX_WAIT,
    ST_T,
    ST_FX_START,
    ST_FX_WAIT,
    ST_D1_DBL,
    ST_D1_ADD,
    ST_D1_SUB,
    ST_D2_DBL,
    ST_D2_QUAD,
    ST_SECX_START,
    ST_SECX_WAIT,
    ST_D2_ADD,
    ST_D2_SUB,
    ST_SHIFT,
    ST_G1_START,
    ST_G1_WAIT,
    ST_O1,
    ST_G2_START,
    ST_G2_WAIT,
    ST_G3_START,
    ST_G3_WAIT,
    ST_EMIT
  } ccr_state_e;

  typedef struct packed {
    dp_op_e          op;
    logic [MW-1:0]   mode;
    logic            last;
  } ccr_cmd_t;

  typedef struct packed {
    logic            mul_done;
    logic            out_free;
    logic [MW-1:0]   count_last;
  } ccr_status_t;

  function automatic logic signed [VW-1:0] sat_addsub(input logic signed [VW-1:0] a,
                                                      input logic signed [VW-1:0] b,
                                                      input logic sub);
    logic signed [VW-1:0] r;
    logic                 ovf;
    r   = sub ? (a - b) : (a + b);
    ovf = sub ? ((a[VW-1] != b[VW-1]) && (r[VW-1] != a[VW-1]))
              : ((a[VW-1] == b[VW-1]) && (r[VW-1] != a[VW-1]));
    return ovf ? (a[VW-1] ? SatMin : SatMax) : r;
  endfunction

endpackage

@@ rtl/ccr_mulsh.sv @@
`timescale 1ns / 1ps

// (a * b) >> sh, truncated toward zero and saturated. One 32x32 multiplier
// forms the low and high partial products in turn, then sums them; done rises with the registered result.
module ccr_mulsh
  import ccr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [VW-1:0] a_i,
  input  logic signed [CW-1:0] b_i,
  input  sh_e                  sh_i,
  output logic                 done_o,
  output logic signed [VW-1:0] res_o
);

  logic [2:0]           phase_q, phase_d;
  logic                 done_q;
  logic                 neg_q, zero_q, ovf_q;
  logic [VW-1:0]        ua_q, plo_q, phi_q, sum_q;
  logic [CW-1:0]        ub_q;
  sh_e                  sh_q;
  logic signed [VW-1:0] res_q;

  logic [VW-1:0]        ua_d, limit, lim_sh, hpart, lo_sh, sum_d, prod;
  logic [CW-1:0]        ub_d, mul_a;
  logic                 ovf_d;
  logic signed [VW-1:0] res_d;

  assign ua_d  = a_i[VW-1] ? (~a_i + 64'd1) : a_i;
  assign ub_d  = b_i[CW-1] ? (~b_i + 32'd1) : b_i;
  assign mul_a = (phase_q == 3'd1) ? ua_q[31:0] : ua_q[63:32];
  assign prod  = VW'(mul_a) * VW'(ub_q);
  assign limit = neg_q ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;

  always_comb begin
    unique case (sh_q)
      SH_24: begin
        lim_sh = limit >> 8;
        hpart  = phi_q << 8;
        lo_sh  = plo_q >> 24;
      end
      SH_29: begin
        lim_sh = limit >> 3;
        hpart  = phi_q << 3;
        lo_sh  = plo_q >> 29;
      end
      SH_30: begin
        lim_sh = limit >> 2;
        hpart  = phi_q << 2;
        lo_sh  = plo_q >> 30;
      end
      default: begin
        lim_sh = limit;
        hpart  = phi_q;
        lo_sh  = plo_q;
      end
    endcase
    ovf_d = phi_q > lim_sh;
    sum_d = hpart + lo_sh;
  end

  always_comb begin
    if (zero_q) begin
      res_d = '0;
    end else if (ovf_q || (sum_q > limit)) begin
      res_d = neg_q ? SatMin : SatMax;
    end else begin
      res_d = neg_q ? $signed(~sum_q + 64'd1) : $signed(sum_q);
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (phase_q == 3'd0) begin
      if (start_i) phase_d = 3'd1;
    end else if (phase_q == 3'd4) begin
      phase_d = 3'd0;
    end else begin
      phase_d = phase_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 3'd0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == 3'd4);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && (phase_q == 3'd0)) begin
      neg_q  <= a_i[VW-1] != b_i[CW-1];
      zero_q <= (a_i == '0) || (b_i == '0);
      ua_q   <= ua_d;
      ub_q   <= ub_d;
      sh_q   <= sh_i;
    end
    if (phase_q == 3'd1) plo_q <= prod;
    if (phase_q == 3'd2) phi_q <= prod;
    if (phase_q == 3'd3) begin
      sum_q <= sum_d;
      ovf_q <= ovf_d;
    end
    if (phase_q == 3'd4) res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/ccr_datapath.sv @@
`timescale 1ns / 1ps

module ccr_datapath
  import ccr_pkg::*;
#(
  parameter int unsigned MAX_MODES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccr_cmd_t            cmd_i,
  output ccr_status_t         status_o,
  input  logic                cfg_valid_i,
  input  logic [IDXW-1:0]     cfg_index_i,
  input  logic [CW-1:0]       cfg_data_i,
  input  logic [XW-1:0]       in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OUTW-1:0]     out_data_o,
  output logic                out_last_o
);

  localparam logic [NW-1:0] MaxModesW = NW'(MAX_MODES);

  logic [NW-1:0]        mode_count_q;
  logic [CW-1:0]        amp_q, gain_q;

  logic [XW-1:0]        x_q;
  logic signed [VW-1:0] p0_q, p1_q, f0_q, f1_q, s0_q, s1_q;
  logic signed [VW-1:0] t_q, d1_q, d2_q, acc_q, o1_q;

  logic                 out_valid_q, out_last_q;
  logic [MW-1:0]        out_mode_q;
  logic signed [VW-1:0] out_poly_q, out_first_q, out_second_q;

  logic signed [VW-1:0] amp_ext, sa, sb, sres, mul_a, mr;
  logic                 ssub, mul_start, mul_done, halve;
  logic signed [CW-1:0] mul_b;
  sh_e                  mul_sh;
  logic [NW-1:0]        count_last;

  assign amp_ext = {{(VW-CW){amp_q[CW-1]}}, amp_q};

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_count_q <= ModeCountRst;
      amp_q        <= ScaleRst;
      gain_q       <= GainRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MODE_COUNT: mode_count_q <= cfg_data_i[NW-1:0];
        CFG_AMP_SCALE:  amp_q        <= cfg_data_i;
        CFG_DERIV_GAIN: gain_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // mode count clamped to [2, MAX_MODES], as last index
  always_comb begin
    if (mode_count_q < 7'd2) begin
      count_last = 7'd1;
    end else if (mode_count_q > MaxModesW) begin
      count_last = MaxModesW - 7'd1;
    end else begin
      count_last = mode_count_q - 7'd1;
    end
  end

  // saturating add/sub operands
  always_comb begin
    sa   = acc_q;
    sb   = mr;
    ssub = 1'b0;
    unique case (cmd_i.op)
      OP_T: begin
        sa   = mr;
        sb   = p1_q;
        ssub = 1'b1;
      end
      OP_ACC_2P: begin
        sa = p0_q;
        sb = p0_q;
      end
      OP_D1: begin
        sb   = f1_q;
        ssub = 1'b1;
      end
      OP_ACC_2F: begin
        sa = f0_q;
        sb = f0_q;
      end
      OP_ACC_DBL: sb = acc_q;
      OP_D2: begin
        sb   = s1_q;
        ssub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sres = sat_addsub(sa, sb, ssub);

  // multiplier operands
  always_comb begin
    mul_start = 1'b1;
    mul_a     = p0_q;
    mul_b     = $signed(x_q);
    mul_sh    = SH_29;
    unique case (cmd_i.op)
      OP_MUL_SX: begin
        mul_a  = amp_ext;
        mul_sh = SH_30;
      end
      OP_MUL_PX:   mul_a = p0_q;
      OP_MUL_FX:   mul_a = f0_q;
      OP_MUL_SECX: mul_a = s0_q;
      OP_MUL_D1G: begin
        mul_a  = d1_q;
        mul_b  = $signed(gain_q);
        mul_sh = SH_24;
      end
      OP_MUL_D2G: begin
        mul_a  = d2_q;
        mul_b  = $signed(gain_q);
        mul_sh = SH_24;
      end
      OP_MUL_MRG: begin
        mul_a  = mr;
        mul_b  = $signed(gain_q);
        mul_sh = SH_24;
      end
      default: mul_start = 1'b0;
    endcase
  end

  ccr_mulsh u_mulsh (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh_i    (mul_sh),
    .done_o  (mul_done),
    .res_o   (mr)
  );

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        x_q  <= in_data_i;
        t_q  <= amp_ext;
        d1_q <= '0;
        d2_q <= '0;
      end
      OP_BASE1: begin
        t_q  <= mr;
        d1_q <= amp_ext;
        d2_q <= '0;
      end
      OP_T:       t_q   <= sres;
      OP_ACC_2P,
      OP_ACC_MR,
      OP_ACC_2F,
      OP_ACC_DBL: acc_q <= sres;
      OP_D1:      d1_q  <= sres;
      OP_D2:      d2_q  <= sres;
      OP_SHIFT: begin
        p1_q <= p0_q;
        p0_q <= t_q;
        f1_q <= f0_q;
        f0_q <= d1_q;
        s1_q <= s0_q;
        s0_q <= d2_q;
      end
      OP_O1:      o1_q  <= mr;
      default: ;
    endcase
  end

  // first and last mode are halved
  assign halve = (cmd_i.mode == '0) || cmd_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      out_mode_q   <= cmd_i.mode;
      out_last_q   <= cmd_i.last;
      out_poly_q   <= halve ? (t_q >>> 1) : t_q;
      out_first_q  <= halve ? (o1_q >>> 1) : o1_q;
      out_second_q <= halve ? (mr >>> 1) : mr;
    end
  end

  assign status_o.mul_done   = mul_done;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.count_last = count_last[MW-1:0];

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {2'b00, out_second_q, out_first_q, out_poly_q, out_mode_q};

endmodule

@@ rtl/ccr_ctrl.sv @@
`timescale 1ns / 1ps

module ccr_ctrl
  import ccr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ccr_status_t status_i,
  output ccr_cmd_t    cmd_o
);

  ccr_state_e    state_q, state_d;
  logic [MW-1:0] mode_q, mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= '0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NOP;
    cmd_o.mode = mode_q;
    cmd_o.last = (mode_q == status_i.count_last);

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          mode_d   = '0;
          state_d  = ST_SHIFT;
        end
      end
      ST_SX_START: begin
        cmd_o.op = OP_MUL_SX;
        state_d  = ST_SX_WAIT;
      end
      ST_SX_WAIT:  if (status_i.mul_done) state_d = ST_BASE1;
      ST_BASE1: begin
        cmd_o.op = OP_BASE1;
        state_d  = ST_SHIFT;
      end
      ST_PX_START: begin
        cmd_o.op = OP_MUL_PX;
        state_d  = ST_PX_WAIT;
      end
      ST_PX_WAIT:  if (status_i.mul_done) state_d = ST_T;
      ST_T: begin
        cmd_o.op = OP_T;
        state_d  = ST_FX_START;
      end
      ST_FX_START: begin
        cmd_o.op = OP_MUL_FX;
        state_d  = ST_FX_WAIT;
      end
      ST_FX_WAIT:  if (status_i.mul_done) state_d = ST_D1_DBL;
      ST_D1_DBL: begin
        cmd_o.op = OP_ACC_2P;
        state_d  = ST_D1_ADD;
      end
      ST_D1_ADD: begin
        cmd_o.op = OP_ACC_MR;
        state_d  = ST_D1_SUB;
      end
      ST_D1_SUB: begin
        cmd_o.op = OP_D1;
        state_d  = ST_D2_DBL;
      end
      // 4*T' is built as two saturating doublings
      ST_D2_DBL: begin
        cmd_o.op = OP_ACC_2F;
        state_d  = ST_D2_QUAD;
      end
      ST_D2_QUAD: begin
        cmd_o.op = OP_ACC_DBL;
        state_d  = ST_SECX_START;
      end
      ST_SECX_START: begin
        cmd_o.op = OP_MUL_SECX;
        state_d  = ST_SECX_WAIT;
      end
      ST_SECX_WAIT: if (status_i.mul_done) state_d = ST_D2_ADD;
      ST_D2_ADD: begin
        cmd_o.op = OP_ACC_MR;
        state_d  = ST_D2_SUB;
      end
      ST_D2_SUB: begin
        cmd_o.op = OP_D2;
        state_d  = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.op = OP_SHIFT;
        state_d  = ST_G1_START;
      end
      ST_G1_START: begin
        cmd_o.op = OP_MUL_D1G;
        state_d  = ST_G1_WAIT;
      end
      ST_G1_WAIT:  if (status_i.mul_done) state_d = ST_O1;
      ST_O1: begin
        cmd_o.op = OP_O1;
        state_d  = ST_G2_START;
      end
      ST_G2_START: begin
        cmd_o.op = OP_MUL_D2G;
        state_d  = ST_G2_WAIT;
      end
      ST_G2_WAIT:  if (status_i.mul_done) state_d = ST_G3_START;
      ST_G3_START: begin
        cmd_o.op = OP_MUL_MRG;
        state_d  = ST_G3_WAIT;
      end
      ST_G3_WAIT:  if (status_i.mul_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          if (cmd_o.last) begin
            state_d = ST_IDLE;
          end else begin
            mode_d  = mode_q + 6'd1;
            state_d = (mode_q == '0) ? ST_SX_START : ST_PX_START;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/chebyshev_collocation_rows.sv @@
`timescale 1ns / 1ps
// The first result is registered after mode 0 runs its shift, three gain products and emit step.
// The point rate is set by the single shared 32x32 multiplier: six products per mode from mode 2 on.
//   A new point is taken only in the idle state, after the last mode of the current point is emitted.
// An output stall holds the sequencer in its emit step until the result is taken.
// Reset (rst_ni, async, active low) clears the sequencer and output valid and
//   loads mode_count = 64, amplitude_scale = deriv_gain = 1.0.
module chebyshev_collocation_rows
  import ccr_pkg::*;
#(
  parameter int unsigned MAX_MODES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [XW-1:0]     s_axis_tdata,   // [31:0] cosine_point
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [5:0] mode_index, [69:6] poly_value, [133:70] first_deriv,
  // [197:134] second_deriv, [199:198] zero
  output logic [OUTW-1:0]   m_axis_tdata,
  output logic              m_axis_tlast,   // last_mode
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IDXW-1:0]   cfg_index_i,
  input  logic [CW-1:0]     cfg_data_i
);

  ccr_cmd_t    cmd;
  ccr_status_t status;

  assign cfg_ready_o = 1'b1;

  ccr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ccr_datapath #(
    .MAX_MODES (MAX_MODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

@@ rtl/ccr_checker.sv @@
`timescale 1ns / 1ps

module ccr_checker
  import ccr_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUTW-1:0]   m_axis_tdata,
  input logic              m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a pending mid-run result means a point is still in progress
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken while a run is in progress");

  a_one_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second point taken right after a transfer");

  // at least two modes per run
  a_last_not_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[5:0] != 6'd0)
    else $error("run ended on mode 0");

endmodule

bind chebyshev_collocation_rows ccr_checker u_ccr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
